>>> rtl/core/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define SWC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/swc_pkg.sv
package swc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    // Drive gain k, signed Q17.16.
    localparam int GAIN_W = 34;
    localparam int GAIN_FRAC = 16;
    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 34'sd65536;
    localparam logic signed [GAIN_W-1:0] GAIN_AT_FULL = 34'sd13107200;

    // Q1.15 unity for amount and wet.
    localparam int AMT_FRAC = 15;
    localparam logic signed [16:0] AMT_ONE = 17'sd32768;
    localparam logic signed [16:0] AMT_MIN = -17'sd32768;
    localparam logic [15:0] WET_ONE = 16'd32768;

    // Gain divider: 33 quotient bits, one per cycle.
    localparam int GDIV_STEPS = 33;
    localparam int GCNT_W = 6;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DRIVE_AMOUNT = 2'd0;
    localparam t_cfg_idx CFG_WET_MIX = 2'd1;

endpackage

>>> rtl/core/soft_clip_waveshaper.sv
// Rational soft-clip waveshaper: each signed sample x is shaped as (1+k)x/(1+k|x|), blended
// with the dry sample by the wet register and saturated. One sample is taken per clock while
// the output is not stalled and the gain divider is idle. The pipeline depth is set by the
// restoring divider, which resolves one quotient bit per pipeline stage. Bubbles collapse, so
// a stalled output still lets new samples enter while any stage is empty. Writing drive_amount
// starts a serial divider for k, which holds s_axis_tready low (none when the amount is 1.0).
// Config index 0 is drive_amount (17-bit signed Q1.15), index 1 is wet_mix (Q1.15, 0..1.0).
module soft_clip_waveshaper #(
    parameter int SAMPLE_BITS = swc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  swc_pkg::t_cfg_idx                       i_cfg_idx,
    input  logic [swc_pkg::CFG_DATA_W-1:0]          i_cfg_wdata,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_in, rest zero pad
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // [SAMPLE_BITS-1:0] sample_out, rest zero pad
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]        o_m_axis_tdata
);
    import swc_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int TW  = ((SAMPLE_BITS+7)/8)*8;
    localparam int GPW = GAIN_W - 1;           // 1+k, never negative
    localparam int NW  = GPW + SB;             // numerator
    localparam int KMW = GAIN_W + SB + 1;      // k*|x|
    localparam int DW  = SB + 34;              // denominator
    localparam int NST = SB + 5;               // pipeline stages
    localparam int PW  = SB + 19;              // (y-x)*wet
    localparam int TOTW = SB + 20;
    localparam int RW  = TOTW - AMT_FRAC;

    // ---------------- configuration and gain divider ----------------
    logic signed [GAIN_W-1:0] r_gain;
    logic [15:0]              r_wet;
    logic                     r_busy;
    logic [GCNT_W-1:0]        r_gcnt;
    logic [GDIV_STEPS-1:0]    r_gnum;
    logic [GDIV_STEPS-1:0]    r_gq;
    logic [16:0]              r_grem;
    logic [16:0]              r_gden;
    logic                     r_gneg;

    logic signed [16:0] cfg_a;
    logic signed [16:0] cfg_ac;
    logic [15:0]        cfg_mag;
    logic [17:0]        g_t;
    logic               g_ge;
    logic [16:0]        n_grem;
    logic [GDIV_STEPS-1:0] n_gq;

    always_comb begin
        cfg_a = $signed(i_cfg_wdata);
        if (cfg_a < AMT_MIN) begin
            cfg_ac = AMT_MIN;
        end else if (cfg_a > AMT_ONE) begin
            cfg_ac = AMT_ONE;
        end else begin
            cfg_ac = cfg_a;
        end
        cfg_mag = cfg_ac[16] ? 16'(-cfg_ac) : cfg_ac[15:0];
        g_t  = {r_grem, r_gnum[GDIV_STEPS-1]};
        g_ge = g_t >= {1'b0, r_gden};
        n_grem = g_ge ? 17'(g_t - {1'b0, r_gden}) : g_t[16:0];
        n_gq   = {r_gq[GDIV_STEPS-2:0], g_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_wet  <= '0;
            r_busy <= 1'b0;
            r_gcnt <= '0;
        end else if (i_cfg_we && i_cfg_idx == CFG_DRIVE_AMOUNT) begin
            if (cfg_ac == AMT_ONE) begin
                r_gain <= GAIN_AT_FULL;
                r_busy <= 1'b0;
            end else begin
                r_busy <= 1'b1;
                r_gcnt <= '0;
                r_gnum <= GDIV_STEPS'({cfg_mag, 17'd0});
                r_grem <= '0;
                r_gq   <= '0;
                r_gden <= 17'(AMT_ONE - cfg_ac);
                r_gneg <= cfg_ac[16];
            end
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_WET_MIX) begin
                r_wet <= (i_cfg_wdata[15:0] > WET_ONE) ? WET_ONE : i_cfg_wdata[15:0];
            end
            if (r_busy) begin
                r_grem <= n_grem;
                r_gq   <= n_gq;
                r_gnum <= {r_gnum[GDIV_STEPS-2:0], 1'b0};
                r_gcnt <= r_gcnt + 1'b1;
                if (r_gcnt == GCNT_W'(GDIV_STEPS-1)) begin
                    r_busy <= 1'b0;
                    r_gain <= r_gneg ? -$signed({1'b0, n_gq}) : $signed({1'b0, n_gq});
                end
            end
        end
    end

    // ---------------- sample pipeline ----------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;
    logic           in_fire;

    always_comb begin
        en[NST-1] = !r_vld[NST-1] || i_m_axis_tready;
        for (int i = NST-2; i >= 0; i--) begin
            en[i] = !r_vld[i] || en[i+1];
        end
    end

    assign o_s_axis_tready = en[0] && !r_busy;
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= in_fire;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // stage 0: input, stage 1: products, stage 2: denominator
    logic signed [SB-1:0]  r_x0, r_x1, r_x2;
    logic [SB-1:0]         r_m0;
    logic [NW-1:0]         r_num1;
    logic signed [KMW-1:0] r_km1;
    logic [DW-1:0]         r_den2;
    logic [DW-1:0]         r_rem2;
    logic                  r_b2;
    logic                  r_zero2;

    logic [GPW-1:0]        gp;
    logic signed [KMW-1:0] den_s;

    assign gp = GPW'(r_gain + GAIN_ONE);
    assign den_s = r_km1 + (KMW'(1) <<< (SB - 1 + GAIN_FRAC));

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x0 <= $signed(i_s_axis_tdata[SB-1:0]);
            r_m0 <= i_s_axis_tdata[SB-1] ? SB'(-$signed(i_s_axis_tdata[SB-1:0]))
                                         : i_s_axis_tdata[SB-1:0];
        end
        if (en[1]) begin
            r_x1   <= r_x0;
            r_num1 <= NW'(gp * r_m0);
            r_km1  <= KMW'($signed({1'b0, r_m0}) * r_gain);
        end
        if (en[2]) begin
            r_x2    <= r_x1;
            r_den2  <= den_s[DW-1:0];
            r_rem2  <= DW'(r_num1 >> 1);
            r_b2    <= r_num1[0];
            r_zero2 <= den_s == '0;
        end
    end

    // divider stages: one quotient bit each
    logic [DW-1:0]        r_drem [SB];
    logic [DW-1:0]        r_dden [SB];
    logic [SB-1:0]        r_dq   [SB];
    logic signed [SB-1:0] r_dx   [SB];
    logic                 r_dz   [SB];
    logic [DW-1:0]        n_drem [SB];
    logic [SB-1:0]        n_dq   [SB];

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int j = 0; j < SB; j++) begin
            if (j == 0) begin
                t = {r_rem2, r_b2};
                ge = t >= {1'b0, r_den2};
                n_drem[j] = ge ? DW'(t - {1'b0, r_den2}) : t[DW-1:0];
                n_dq[j] = SB'(ge);
            end else begin
                t = {r_drem[j-1], 1'b0};
                ge = t >= {1'b0, r_dden[j-1]};
                n_drem[j] = ge ? DW'(t - {1'b0, r_dden[j-1]}) : t[DW-1:0];
                n_dq[j] = {r_dq[j-1][SB-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SB; j++) begin
            if (en[3+j]) begin
                r_drem[j] <= n_drem[j];
                r_dq[j]   <= n_dq[j];
                r_dden[j] <= (j == 0) ? r_den2 : r_dden[j-1];
                r_dx[j]   <= (j == 0) ? r_x2 : r_dx[j-1];
                r_dz[j]   <= (j == 0) ? r_zero2 : r_dz[j-1];
            end
        end
    end

    // mix stages
    logic signed [SB:0]     ys;
    logic signed [SB+1:0]   diff;
    logic signed [PW-1:0]   r_prod;
    logic signed [SB-1:0]   r_xm;
    logic signed [SB-1:0]   r_out;
    logic signed [TOTW-1:0] total;
    logic signed [TOTW-1:0] adj;
    logic signed [RW-1:0]   res;

    always_comb begin
        if (r_dz[SB-1]) begin
            ys = '0;
        end else if (r_dx[SB-1][SB-1]) begin
            ys = -$signed({1'b0, r_dq[SB-1]});
        end else begin
            ys = $signed({1'b0, r_dq[SB-1]});
        end
        diff  = (SB+2)'(ys) - (SB+2)'(r_dx[SB-1]);
        total = (TOTW'(r_xm) <<< AMT_FRAC) + TOTW'(r_prod);
        adj   = total[TOTW-1] ? total + TOTW'((1 << AMT_FRAC) - 1) : total;
        res   = RW'(adj >>> AMT_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-2]) begin
            r_prod <= PW'(diff * $signed({1'b0, r_wet}));
            r_xm   <= r_dx[SB-1];
        end
        if (en[NST-1]) begin
            if (res > RW'((1 << (SB-1)) - 1)) begin
                r_out <= {1'b0, {(SB-1){1'b1}}};
            end else if (res < -(RW'(1) <<< (SB-1))) begin
                r_out <= {1'b1, {(SB-1){1'b0}}};
            end else begin
                r_out <= res[SB-1:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = TW'(unsigned'(r_out));

    `include "assert_macros.svh"

    `SWC_ASSERT(a_amt_starts_div, (i_cfg_we && i_cfg_idx == CFG_DRIVE_AMOUNT && $signed(i_cfg_wdata) < AMT_ONE) |=> r_busy, "gain divider did not start")
    `SWC_ASSERT(a_gain_range, !r_busy |-> (r_gain >= -GAIN_ONE), "drive gain below -1.0")
    `SWC_ASSERT(a_quot_range, (r_vld[NST-3] && !r_dz[SB-1]) |-> (r_dq[SB-1] <= (SB'(1) << (SB-1))), "shaped magnitude above full scale")
    `SWC_ASSERT(a_no_accept_busy, r_busy |-> !in_fire, "sample accepted while gain pending")

endmodule
